@@ rtl/aecho_pkg.sv @@
`timescale 1ns / 1ps
package aecho_pkg;

    // Delay memory; depth must be a power of two so the ring pointer wraps.
    localparam int DELAY_DEPTH = 32768;
    localparam int ADDR_W      = $clog2(DELAY_DEPTH);
    localparam int FILL_W      = ADDR_W + 1;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 12;
    localparam int MS_W     = 11;
    localparam int RATE_W   = 18;

    localparam logic [GAIN_W-1:0] GAIN_MAX   = 12'd2560;
    localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

    // Delay conversion: floor((ms * rate + 500) / 1000) as a reciprocal multiply.
    localparam int NUM_W       = MS_W + RATE_W + 1;
    localparam int RECIP_SHIFT = 40;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [NUM_W-1:0]   HALF_MS    = NUM_W'(500);
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);
    localparam logic [ADDR_W-1:0]  DELAY_MAX  = ADDR_W'(DELAY_DEPTH - 1);

    // Configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_GAIN  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELAY = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RATE  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       clip_start;
        logic                       clip_end;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       end_out;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [ADDR_W-1:0] delay;
        logic              busy;
    } cfg_t;

endpackage

@@ rtl/aecho_dcalc.sv @@
`timescale 1ns / 1ps
module aecho_dcalc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [aecho_pkg::MS_W-1:0]    delay_ms,
    input  logic [aecho_pkg::RATE_W-1:0]  rate_hz,
    output logic [aecho_pkg::ADDR_W-1:0]  delay,
    output logic                          busy
);
    import aecho_pkg::*;

    logic [2:0]          stage_vld_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   delay_reg;
    logic [QUOT_W-1:0]   quot;
    logic [ADDR_W-1:0]   delay_next;

    always_comb
    begin
        quot = prod_reg[PROD_W-1:RECIP_SHIFT];
        if (quot > QUOT_W'(DELAY_MAX))
        begin
            delay_next = DELAY_MAX;
        end
        else
        begin
            delay_next = quot[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= '0;
            delay_reg     <= '0;
        end
        else
        begin
            stage_vld_reg <= {stage_vld_reg[1:0], start};
            if (stage_vld_reg[2])
            begin
                delay_reg <= delay_next;
            end
        end
    end

    // Payload stages: product plus rounding offset, then reciprocal multiply.
    always_ff @(posedge clk)
    begin
        if (stage_vld_reg[0])
        begin
            num_reg <= NUM_W'(delay_ms) * NUM_W'(rate_hz) + HALF_MS;
        end
        if (stage_vld_reg[1])
        begin
            prod_reg <= PROD_W'(num_reg) * PROD_W'(RECIP_MULT);
        end
    end

    assign delay = delay_reg;
    assign busy  = |stage_vld_reg;

endmodule

@@ rtl/aecho_regs.sv @@
`timescale 1ns / 1ps
module aecho_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aecho_pkg::PADDR_W-1:0] paddr,
    input  logic [aecho_pkg::PDATA_W-1:0] pwdata,
    output logic [aecho_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output aecho_pkg::cfg_t               cfg
);
    import aecho_pkg::*;

    logic [GAIN_W-1:0]    gain_reg;
    logic [MS_W-1:0]      ms_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic                 calc_start_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [ADDR_W-1:0]    delay;
    logic                 calc_busy;

    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= '0;
            ms_reg         <= '0;
            rate_reg       <= RATE_RESET;
            calc_start_reg <= 1'b0;
        end
        else
        begin
            calc_start_reg <= 1'b0;
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_GAIN:  gain_reg <= pwdata[GAIN_W-1:0];
                    REG_DELAY:
                    begin
                        ms_reg         <= pwdata[MS_W-1:0];
                        calc_start_reg <= 1'b1;
                    end
                    REG_RATE:
                    begin
                        rate_reg       <= pwdata[RATE_W-1:0];
                        calc_start_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN:  prdata = PDATA_W'(gain_reg);
            REG_DELAY: prdata = PDATA_W'(ms_reg);
            REG_RATE:  prdata = PDATA_W'(rate_reg);
            default:   prdata = '0;
        endcase
    end

    aecho_dcalc u_dcalc (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (calc_start_reg),
        .delay_ms (ms_reg),
        .rate_hz  (rate_reg),
        .delay    (delay),
        .busy     (calc_busy)
    );

    // Hold off items from the write edge until the new delay lands.
    always_comb
    begin
        cfg.gain  = gain_reg;
        cfg.delay = delay;
        cfg.busy  = calc_start_reg || calc_busy;
    end

endmodule

@@ rtl/aecho_core.sv @@
`timescale 1ns / 1ps
module aecho_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aecho_pkg::cfg_t      cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aecho_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aecho_pkg::out_item_t out_data
);
    import aecho_pkg::*;

    localparam logic [1:0] PAST_ZERO = 2'd0;
    localparam logic [1:0] PAST_SELF = 2'd1;
    localparam logic [1:0] PAST_MEM  = 2'd2;
    localparam int ACC_W = SAMPLE_W + GAIN_W + 1;
    localparam int Q_W   = ACC_W - 8;

    logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];

    logic [ADDR_W-1:0]          wp_reg;
    logic [FILL_W-1:0]          fill_reg;
    logic [FILL_W-1:0]          fill_base;
    logic [FILL_W-1:0]          fill_next;
    logic [ADDR_W-1:0]          rd_addr;
    logic [1:0]                 sel_next;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic                       s1_end_reg;
    logic [1:0]                 s1_sel_reg;
    logic [SAMPLE_W-1:0]        rd_data_reg;

    logic                       out_valid_reg;
    out_item_t                  out_data_reg;
    out_item_t                  out_data_next;

    logic                       accept;
    logic                       s1_advance;

    logic [GAIN_W-1:0]          gain_c;
    logic signed [SAMPLE_W-1:0] past;
    logic signed [ACC_W-1:0]    prod;
    logic signed [ACC_W-1:0]    acc;
    logic signed [Q_W-1:0]      q;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !cfg.busy && (!s1_valid_reg || s1_advance);
    assign accept     = in_valid && in_ready;

    // Stage 0: pick the echo source and address the delay memory.
    always_comb
    begin
        fill_base = in_data.clip_start ? '0 : fill_reg;
        fill_next = (fill_base < FILL_W'(DELAY_DEPTH)) ? fill_base + 1'b1 : fill_base;
        rd_addr   = wp_reg - cfg.delay;
        if (cfg.delay == '0)
        begin
            sel_next = PAST_SELF;
        end
        else if (fill_base >= FILL_W'(cfg.delay))
        begin
            sel_next = PAST_MEM;
        end
        else
        begin
            sel_next = PAST_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[wp_reg] <= in_data.sample_in;
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Stage 1: scale, add, truncate toward zero, saturate.
    always_comb
    begin
        gain_c = (cfg.gain > GAIN_MAX) ? GAIN_MAX : cfg.gain;
        unique case (s1_sel_reg)
            PAST_SELF: past = s1_x_reg;
            PAST_MEM:  past = $signed(rd_data_reg);
            default:   past = '0;
        endcase
        prod = $signed({1'b0, gain_c}) * ACC_W'(past);
        acc  = prod + $signed({ {(ACC_W-SAMPLE_W-8){s1_x_reg[SAMPLE_W-1]}}, s1_x_reg, 8'd0 });
        q    = acc[ACC_W-1:8] + Q_W'(acc[ACC_W-1] && (acc[7:0] != 8'd0));
        if (q > Q_W'(32767))
        begin
            out_data_next.sample_out = 16'sh7FFF;
        end
        else if (q < -Q_W'(32768))
        begin
            out_data_next.sample_out = 16'sh8000;
        end
        else
        begin
            out_data_next.sample_out = q[SAMPLE_W-1:0];
        end
        out_data_next.end_out = s1_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wp_reg   <= wp_reg + 1'b1;
                fill_reg <= fill_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg   <= in_data.sample_in;
            s1_end_reg <= in_data.clip_end;
            s1_sel_reg <= sel_next;
        end
        if (s1_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/audio_echo_saturating_unit.sv @@
`timescale 1ns / 1ps
// Channel  Handshake                 Payload
// in       in_valid / in_ready       in_data  (sample_in, clip_start, clip_end)
// out      out_valid / out_ready     out_data (sample_out, end_out)
// cfg      psel, penable, pwrite     paddr, pwdata, prdata (pready tied high)
//
// One item per cycle while out_ready is high and no delay update is pending. An
// accepted item passes the stage-one registers (registered delay-memory read),
// then the output register. A write to the delay or rate register holds in_ready
// low while the delay in samples passes the three-stage reciprocal multiply.
// Reset clears pointers, fill count and valids; the delay memory is not cleared.
// A stalled output holds its item; in_ready follows out_ready through the pipe.
module audio_echo_saturating_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  aecho_pkg::in_item_t           in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output aecho_pkg::out_item_t          out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aecho_pkg::PADDR_W-1:0] paddr,
    input  logic [aecho_pkg::PDATA_W-1:0] pwdata,
    output logic [aecho_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import aecho_pkg::*;

    cfg_t cfg;

    aecho_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aecho_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/aecho_checker.sv @@
`timescale 1ns / 1ps
module aecho_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input aecho_pkg::out_item_t          out_data,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [aecho_pkg::PADDR_W-1:0] paddr,
    input logic                          pready
);
    import aecho_pkg::*;

    logic [2:0] pending_reg;
    logic       in_acc;
    logic       out_acc;
    logic       delay_wr;

    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid && out_ready;
    assign delay_wr = psel && penable && pwrite && pready &&
                      ((paddr[PADDR_W-1:PADDR_W-REG_IDX_W] == REG_DELAY) ||
                       (paddr[PADDR_W-1:PADDR_W-REG_IDX_W] == REG_RATE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 3'(in_acc) - 3'(out_acc);
        end
    end

    // Hold a stalled result item.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // At most the stage-one and output registers are in flight.
    a_pending_max: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more than two items in flight");

    // Every result comes from an accepted item.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result item without an accepted input");

    // Stall input while the new delay is being worked out.
    a_delay_busy: assert property (@(posedge clk) disable iff (!rst_n)
        delay_wr |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input accepted during delay update");

endmodule

bind audio_echo_saturating_unit aecho_checker u_aecho_checker (.*);
